// ----- rtl/frt_pkg.sv -----
// Package with shared types and constants of the fragment reassembly tracker.
package frt_pkg;

   localparam int TABLE_ENTRIES = 8;
   localparam int FRAGMENTS     = 16;
   localparam int LENGTH_BITS   = 11;

   localparam int SLOT_BITS  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FIDX_BITS  = (FRAGMENTS > 1) ? $clog2(FRAGMENTS) : 1;
   localparam int AGE_BITS   = SLOT_BITS;
   localparam int LMEM_DEPTH = TABLE_ENTRIES * FRAGMENTS;
   localparam int LMEM_BITS  = SLOT_BITS + FIDX_BITS;
   localparam int SUM_BITS   = 15;
   localparam logic [SUM_BITS-1:0] LEN_MAX = 15'h7FFF;

   typedef struct packed {
      logic        fragmented;
      logic [15:0] sequence_number;
      logic [4:0]  fragment_index;
      logic        last_fragment;
      logic [10:0] payload_length;
   } req_type;

   typedef struct packed {
      logic        message_ready;
      logic [31:0] message_id;
      logic [15:0] message_sequence;
      logic [14:0] message_length;
      logic        was_reassembled;
      logic        entry_evicted;
      logic [15:0] evicted_sequence;
      logic        fragment_dropped;
   } rsp_type;

   // Work item handed from the classifier to the back end.
   typedef struct packed {
      logic        fragmented;
      logic        dropped;
      logic [15:0] sequence_number;
      logic [FIDX_BITS-1:0] fragment_index;
      logic        last_fragment;
      logic [LENGTH_BITS-1:0] payload_length;
   } work_type;

endpackage

// ----- rtl/frt_if.sv -----
// Valid/ready channel interface carrying one transaction payload.
interface frt_if #(parameter type payload_type = logic) (input logic clock);
   logic        valid;
   logic        ready;
   payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/frt_ram.sv -----
// Generic single-port write, single-port registered read RAM.
module frt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ----- rtl/frt_front.sv -----
// Front end: accepts packet headers, classifies them, and feeds a small queue.
module frt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  frt_pkg::req_type    in_data,
   output logic                wq_valid,
   input  logic                wq_pop,
   output frt_pkg::work_type   wq_data
);
   // Two-entry queue decouples header intake from table processing.
   frt_pkg::work_type q_ff [2];
   logic [1:0] cnt_ff, cnt_in;
   logic       rd_ff, wr_ff;
   frt_pkg::work_type w;
   logic push;

   always_comb begin
      w.fragmented      = in_data.fragmented;
      w.dropped         = in_data.fragmented &&
                          (32'(in_data.fragment_index) >= frt_pkg::FRAGMENTS);
      w.sequence_number = in_data.sequence_number;
      w.fragment_index  = in_data.fragment_index[frt_pkg::FIDX_BITS-1:0];
      w.last_fragment   = in_data.last_fragment;
      w.payload_length  = in_data.payload_length[frt_pkg::LENGTH_BITS-1:0];
   end

   assign in_ready = (cnt_ff != 2'd2);
   assign push     = in_valid && in_ready;
   assign wq_valid = (cnt_ff != 2'd0);
   assign wq_data  = q_ff[rd_ff];
   assign cnt_in   = cnt_ff + 2'(push) - 2'(wq_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) wr_ff <= ~wr_ff;
         if (wq_pop) rd_ff <= ~rd_ff;
      end
      if (push) q_ff[wr_ff] <= w;
   end
endmodule

// ----- rtl/frt_back.sv -----
// Back end: table match, entry update, and fragment length summation.
module frt_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               wq_valid,
   output logic               wq_pop,
   input  frt_pkg::work_type  wq_data,
   output logic               out_valid,
   input  logic               out_ready,
   output frt_pkg::rsp_type   out_data
);
   localparam int N  = frt_pkg::TABLE_ENTRIES;
   localparam int SB = frt_pkg::SLOT_BITS;
   localparam int FB = frt_pkg::FIDX_BITS;
   localparam int F  = frt_pkg::FRAGMENTS;

   typedef enum logic [2:0] {S_IDLE, S_UPDATE, S_SUM, S_DRAIN, S_OUT} state_type;
   state_type state_ff;

   logic          valid_ff [N];
   logic [15:0]   seq_ff   [N];
   logic [SB-1:0] age_ff   [N];
   logic          hasf_ff  [N];
   logic [FB-1:0] fin_ff   [N];
   logic [F-1:0]  map_ff   [N];
   logic [31:0]   cnt_ff;

   frt_pkg::work_type w_ff;
   frt_pkg::rsp_type  r_ff;
   logic [SB-1:0]     slot_ff;
   logic [FB:0]       sidx_ff;
   logic [FB-1:0]     sfin_ff;
   logic [15:0]       sum_ff;
   logic              pend_ff;

   // Combinational lookup on the current work item.
   logic          found, got_free;
   logic [SB-1:0] hit_s, free_s, old_s;
   always_comb begin
      found = 1'b0; got_free = 1'b0;
      hit_s = '0; free_s = '0; old_s = '0;
      for (int i = N - 1; i >= 0; i--) begin
         if (valid_ff[i] && seq_ff[i] == w_ff.sequence_number) begin
            found = 1'b1; hit_s = SB'(i);
         end
         if (!valid_ff[i]) begin
            got_free = 1'b1; free_s = SB'(i);
         end
      end
      // With a full table the ages are a permutation, so the oldest holds the maximum.
      for (int i = 0; i < N; i++) begin
         if (age_ff[i] == SB'(N - 1)) old_s = SB'(i);
      end
   end

   logic          lw_en;
   logic [frt_pkg::LMEM_BITS-1:0] lw_addr, lr_addr;
   logic [frt_pkg::LENGTH_BITS-1:0] lr_data;
   logic [SB-1:0] tgt;
   logic [F-1:0]  nmap;
   logic          nhasf;
   logic [FB-1:0] nfin;

   always_comb begin
      tgt   = found ? hit_s : (got_free ? free_s : old_s);
      nmap  = (found ? map_ff[tgt] : '0) | (F'(1) << w_ff.fragment_index);
      nhasf = (found && hasf_ff[tgt]) || w_ff.last_fragment;
      nfin  = w_ff.last_fragment ? w_ff.fragment_index :
              (found ? fin_ff[tgt] : '0);
      lw_en   = (state_ff == S_UPDATE);
      lw_addr = {tgt, w_ff.fragment_index};
      lr_addr = {slot_ff, sidx_ff[FB-1:0]};
   end

   frt_ram #(.WIDTH(frt_pkg::LENGTH_BITS), .DEPTH(frt_pkg::LMEM_DEPTH)) u_len (
      .clock(clock), .wr_en(lw_en), .wr_addr(lw_addr), .wr_data(w_ff.payload_length),
      .rd_addr(lr_addr), .rd_data(lr_data)
   );

   logic complete;
   logic [F-1:0] need;
   always_comb begin
      need     = (F'(2) << nfin) - F'(1);
      complete = nhasf && ((nmap & need) == need);
   end

   assign wq_pop    = (state_ff == S_IDLE) && wq_valid;
   assign out_valid = (state_ff == S_OUT);
   assign out_data  = r_ff;

   logic [16:0] sum_in;
   assign sum_in = {1'b0, sum_ff} + 17'(lr_data);

   // Result built in the update cycle, and the same result completed with the
   // reassembled message in the drain cycle.
   frt_pkg::rsp_type upd_rsp, drain_rsp;
   always_comb begin
      upd_rsp = '0;
      if (!w_ff.fragmented) begin
         if (w_ff.payload_length != '0) begin
            upd_rsp.message_ready    = 1'b1;
            upd_rsp.message_id       = cnt_ff + 32'd1;
            upd_rsp.message_sequence = w_ff.sequence_number;
            upd_rsp.message_length   = 15'(w_ff.payload_length);
         end
      end else if (w_ff.dropped) begin
         upd_rsp.fragment_dropped = 1'b1;
      end else if (!found && !got_free) begin
         upd_rsp.entry_evicted    = 1'b1;
         upd_rsp.evicted_sequence = seq_ff[old_s];
      end
      drain_rsp                  = r_ff;
      drain_rsp.message_ready    = 1'b1;
      drain_rsp.message_id       = cnt_ff + 32'd1;
      drain_rsp.message_sequence = w_ff.sequence_number;
      drain_rsp.message_length   = (sum_in > 17'(frt_pkg::LEN_MAX)) ?
                                   frt_pkg::LEN_MAX : sum_in[14:0];
      drain_rsp.was_reassembled  = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff   <= '0;
         for (int i = 0; i < N; i++) begin
            valid_ff[i] <= 1'b0;
            age_ff[i]   <= '0;
            hasf_ff[i]  <= 1'b0;
            fin_ff[i]   <= '0;
            map_ff[i]   <= '0;
         end
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (wq_valid) begin
                  w_ff     <= wq_data;
                  state_ff <= S_UPDATE;
               end
            end
            S_UPDATE: begin
               r_ff <= upd_rsp;
               if (!w_ff.fragmented) begin
                  if (w_ff.payload_length != '0) begin
                     cnt_ff <= cnt_ff + 32'd1;
                  end
                  state_ff <= S_OUT;
               end else if (w_ff.dropped) begin
                  state_ff <= S_OUT;
               end else begin
                  slot_ff <= tgt;
                  seq_ff[tgt]  <= w_ff.sequence_number;
                  map_ff[tgt]  <= nmap;
                  hasf_ff[tgt] <= nhasf;
                  fin_ff[tgt]  <= nfin;
                  if (complete) begin
                     // Entry leaves the table; the ages of older entries close the gap.
                     if (found) begin
                        valid_ff[tgt] <= 1'b0;
                        for (int i = 0; i < N; i++)
                           if (valid_ff[i] && age_ff[i] > age_ff[tgt])
                              age_ff[i] <= age_ff[i] - SB'(1);
                     end else if (!got_free) begin
                        valid_ff[tgt] <= 1'b0;
                     end
                     sidx_ff  <= '0;
                     sfin_ff  <= nfin;
                     sum_ff   <= '0;
                     pend_ff  <= 1'b0;
                     state_ff <= S_SUM;
                  end else begin
                     if (!found) begin
                        // Insert as newest; an evicted slot is reused in place.
                        for (int i = 0; i < N; i++)
                           if (valid_ff[i] && SB'(i) != tgt)
                              age_ff[i] <= age_ff[i] + SB'(1);
                        age_ff[tgt]   <= '0;
                        valid_ff[tgt] <= 1'b1;
                     end
                     state_ff <= S_OUT;
                  end
               end
            end
            S_SUM: begin
               // One read issued per cycle; its data is accumulated in the next cycle.
               if (pend_ff)
                  sum_ff <= (sum_in > 17'(frt_pkg::LEN_MAX)) ? 16'(frt_pkg::LEN_MAX)
                                                             : sum_in[15:0];
               pend_ff <= 1'b1;
               if (sidx_ff[FB-1:0] == sfin_ff) state_ff <= S_DRAIN;
               else sidx_ff <= sidx_ff + (FB+1)'(1);
            end
            S_DRAIN: begin
               r_ff     <= drain_rsp;
               cnt_ff   <= cnt_ff + 32'd1;
               state_ff <= S_OUT;
            end
            S_OUT: begin
               if (out_ready) state_ff <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ----- rtl/fragment_reassembly_tracker_core.sv -----
// Each accepted transaction passes the queue and the back-end states idle, update and output;
// a completed message also passes the sum and drain states, one fragment length read per cycle.
// The back-end sequencer takes a new transaction only after the last result has been taken.
// A two-entry queue keeps intake open while the back end works or the result waits, until it is full.
// Synchronous active-high reset clears the table valid bits, ages, maps and the
// message counter; stored sequence numbers and fragment lengths are not cleared.
module fragment_reassembly_tracker_core (
   input logic clock,
   input logic reset,
   frt_if.sink   req,
   frt_if.source rsp
);
   logic              wq_valid, wq_pop;
   frt_pkg::work_type wq_data;

   // Front end classifies each incoming header transaction and queues it.
   frt_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req.valid), .in_ready(req.ready), .in_data(req.payload),
      .wq_valid(wq_valid), .wq_pop(wq_pop), .wq_data(wq_data)
   );

   // Back end owns the reassembly table and builds each result transaction.
   frt_back u_back (
      .clock(clock), .reset(reset),
      .wq_valid(wq_valid), .wq_pop(wq_pop), .wq_data(wq_data),
      .out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.payload)
   );
endmodule

// ----- tb/frt_checker.sv -----
// Checker that predicts tracker results from observed requests and compares them.
`timescale 1ns / 1ps
module frt_checker (
   input  logic clock,
   input  logic reset,
   frt_if.sink  req_mon,
   frt_if.sink  rsp_mon,
   output int   fail_count,
   output int   pending_count
);
   logic              slot_valid [frt_pkg::TABLE_ENTRIES];
   logic [15:0]       slot_seq   [frt_pkg::TABLE_ENTRIES];
   int unsigned       slot_age   [frt_pkg::TABLE_ENTRIES];
   logic              slot_has_final [frt_pkg::TABLE_ENTRIES];
   int unsigned       slot_final [frt_pkg::TABLE_ENTRIES];
   logic [31:0]       slot_map   [frt_pkg::TABLE_ENTRIES];
   logic [frt_pkg::LENGTH_BITS-1:0] frag_len [frt_pkg::TABLE_ENTRIES][frt_pkg::FRAGMENTS];
   logic [31:0]       msg_count;
   frt_pkg::rsp_type  expected_rsps [$];

   assign pending_count = expected_rsps.size();

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
      $display("ERROR %0t: %s got %0h expected %0h", $realtime, what, got, want);
      fail_count++;
   endtask

   function automatic void drop_slot(int s);
      slot_valid[s] = 0;
      for (int i = 0; i < frt_pkg::TABLE_ENTRIES; i++)
         if (slot_valid[i] && slot_age[i] > slot_age[s]) slot_age[i]--;
   endfunction

   function automatic frt_pkg::rsp_type track_packet(frt_pkg::req_type p);
      frt_pkg::rsp_type r;
      int s;
      bit hit, fresh, freeslot;
      int old;
      logic [31:0] need;
      int unsigned sum;
      r = '0; s = 0; hit = 0; fresh = 0; freeslot = 0; old = 0;
      if (!p.fragmented) begin
         if (p.payload_length != 0) begin
            msg_count++;
            r.message_ready = 1'b1; r.message_id = msg_count;
            r.message_sequence = p.sequence_number;
            r.message_length = 15'(p.payload_length);
         end
         return r;
      end
      if (p.fragment_index >= frt_pkg::FRAGMENTS) begin
         r.fragment_dropped = 1'b1;
         return r;
      end
      for (int i = 0; i < frt_pkg::TABLE_ENTRIES; i++)
         if (!hit && slot_valid[i] && slot_seq[i] == p.sequence_number) begin
            s = i; hit = 1;
         end
      if (!hit) begin
         for (int i = 0; i < frt_pkg::TABLE_ENTRIES; i++)
            if (!freeslot && !slot_valid[i]) begin
               s = i; freeslot = 1;
            end
         if (!freeslot) begin
            for (int i = 1; i < frt_pkg::TABLE_ENTRIES; i++)
               if (slot_age[i] > slot_age[old]) old = i;
            r.entry_evicted = 1'b1;
            r.evicted_sequence = slot_seq[old];
            drop_slot(old);
            s = old;
         end
         slot_seq[s] = p.sequence_number;
         slot_has_final[s] = 0; slot_final[s] = 0; slot_map[s] = 0;
         fresh = 1;
      end
      frag_len[s][p.fragment_index] = p.payload_length;
      slot_map[s][p.fragment_index] = 1'b1;
      if (p.last_fragment) begin
         slot_has_final[s] = 1; slot_final[s] = p.fragment_index;
      end
      need = (32'd2 << slot_final[s]) - 32'd1;
      if (slot_has_final[s] && (slot_map[s] & need) == need) begin
         sum = 0;
         for (int i = 0; i <= slot_final[s]; i++) sum += frag_len[s][i];
         if (sum > 32767) sum = 32767;
         msg_count++;
         r.message_ready = 1'b1; r.message_id = msg_count;
         r.message_sequence = p.sequence_number;
         r.message_length = 15'(sum); r.was_reassembled = 1'b1;
         if (!fresh) drop_slot(s);
      end else if (fresh) begin
         for (int i = 0; i < frt_pkg::TABLE_ENTRIES; i++)
            if (slot_valid[i]) slot_age[i]++;
         slot_age[s] = 0; slot_valid[s] = 1;
      end
      return r;
   endfunction

   always @(posedge clock) begin
      frt_pkg::rsp_type got, want;
      if (reset) begin
         for (int i = 0; i < frt_pkg::TABLE_ENTRIES; i++) begin
            slot_valid[i] = 0; slot_age[i] = 0; slot_map[i] = 0;
            slot_has_final[i] = 0; slot_final[i] = 0; slot_seq[i] = 0;
         end
         msg_count = 0;
         expected_rsps.delete();
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_rsps.push_back(track_packet(req_mon.payload));
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            if (expected_rsps.size() == 0) begin
               report("unexpected result", got.message_id, 0);
            end else begin
               want = expected_rsps.pop_front();
               if (got.message_ready !== want.message_ready)
                  report("message_ready", got.message_ready, want.message_ready);
               if (got.message_id !== want.message_id)
                  report("message_id", got.message_id, want.message_id);
               if (got.message_sequence !== want.message_sequence)
                  report("message_sequence", got.message_sequence, want.message_sequence);
               if (got.message_length !== want.message_length)
                  report("message_length", got.message_length, want.message_length);
               if (got.was_reassembled !== want.was_reassembled)
                  report("was_reassembled", got.was_reassembled, want.was_reassembled);
               if (got.entry_evicted !== want.entry_evicted)
                  report("entry_evicted", got.entry_evicted, want.entry_evicted);
               if (got.evicted_sequence !== want.evicted_sequence)
                  report("evicted_sequence", got.evicted_sequence, want.evicted_sequence);
               if (got.fragment_dropped !== want.fragment_dropped)
                  report("fragment_dropped", got.fragment_dropped, want.fragment_dropped);
            end
         end
      end
   end

   initial fail_count = 0;
endmodule

// ----- tb/fragment_reassembly_tracker_core_tb.sv -----
// Top of the tracker testbench: clock, reset, packet stimulus and verdict.
`timescale 1ns / 1ps
module fragment_reassembly_tracker_core_tb;
   logic clock = 0;
   logic reset = 1;
   int   fail_count, pending_count;

   frt_if #(.payload_type(frt_pkg::req_type)) req_ch (clock);
   frt_if #(.payload_type(frt_pkg::rsp_type)) rsp_ch (clock);

   fragment_reassembly_tracker_core dut (
      .clock(clock), .reset(reset), .req(req_ch.sink), .rsp(rsp_ch.source)
   );

   frt_checker checker_i (
      .clock(clock), .reset(reset), .req_mon(req_ch), .rsp_mon(rsp_ch),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // The receiver normally stalls on a random pattern. When long_hold is raised
   // it holds ready low for a counted stretch so the internal queue fills up.
   bit long_hold = 0;
   bit hold_done = 0;
   initial begin
      rsp_ch.ready = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ch.ready <= 0;
            for (int i = 0; i < 60; i++) @(negedge clock);
            hold_done = 1;
            long_hold = 0;
         end else begin
            // Alternating phases: sometimes ready stays up, sometimes it flickers.
            rsp_ch.ready <= ($urandom_range(0, 99) <
                             ((($time / 2000) % 2 != 0) ? 100 : 60));
         end
      end
   end

   // A small pool of sequence numbers keeps fragments of a message colliding
   // with open table entries; occasional wide values still exercise every bit.
   logic [15:0] seq_pool [12];

   task automatic send_packet(input frt_pkg::req_type p);
      req_ch.valid   <= 1;
      req_ch.payload <= p;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_ch.valid <= 0;
      req_ch.payload <= frt_pkg::req_type'($urandom);
      repeat (cycles) @(negedge clock);
   endtask

   function automatic frt_pkg::req_type make_packet(bit frag, logic [15:0] sq,
                                                    logic [4:0] ix, bit lst,
                                                    logic [10:0] ln);
      frt_pkg::req_type p;
      p.fragmented = frag; p.sequence_number = sq; p.fragment_index = ix;
      p.last_fragment = lst; p.payload_length = ln;
      return p;
   endfunction

   // Sends a whole message of random size in random order, with an optional
   // missing or duplicate fragment so that partial entries linger in the table.
   task automatic send_message(input logic [15:0] sq, output int count);
      int n, order [$];
      int lenpick;
      n = ($urandom_range(0, 9) == 0) ? frt_pkg::FRAGMENTS : $urandom_range(1, 5);
      for (int i = 0; i < n; i++) order.push_back(i);
      order.shuffle();
      if ($urandom_range(0, 5) == 0) void'(order.pop_back());
      if ($urandom_range(0, 5) == 0) order.push_back($urandom_range(0, n - 1));
      count = order.size();
      foreach (order[k]) begin
         lenpick = ($urandom_range(0, 7) == 0) ? 2047 : $urandom_range(0, 2047);
         send_packet(make_packet(1'b1, sq, 5'(order[k]), order[k] == n - 1,
                                 11'(lenpick)));
         if ($urandom_range(0, 3) == 0) idle_sender($urandom_range(1, 6));
      end
   endtask

   initial begin
      frt_pkg::req_type p;
      int sent;
      int msg_items;
      bit drained;
      req_ch.valid = 0;
      req_ch.payload = '0;
      drained = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // Directed: empty and full-length plain packets, dropped indexes,
      // immediate completion, duplicates, a repeated last flag, eviction.
      send_packet(make_packet(1'b0, 16'h0000, 5'd0, 1'b0, 11'd0));
      send_packet(make_packet(1'b0, 16'hFFFF, 5'd31, 1'b1, 11'd2047));
      send_packet(make_packet(1'b1, 16'h1234, 5'd16, 1'b0, 11'd5));
      send_packet(make_packet(1'b1, 16'h1234, 5'd31, 1'b1, 11'd2047));
      send_packet(make_packet(1'b1, 16'hFFFF, 5'd0, 1'b1, 11'd2047));
      send_packet(make_packet(1'b1, 16'h0001, 5'd1, 1'b0, 11'd100));
      send_packet(make_packet(1'b1, 16'h0001, 5'd1, 1'b0, 11'd200));
      send_packet(make_packet(1'b1, 16'h0001, 5'd2, 1'b1, 11'd7));
      send_packet(make_packet(1'b1, 16'h0001, 5'd1, 1'b1, 11'd9));
      send_packet(make_packet(1'b1, 16'h0001, 5'd0, 1'b0, 11'd11));
      for (int i = 0; i < 10; i++)
         send_packet(make_packet(1'b1, 16'(16'h0100 + i), 5'd3, 1'b0, 11'(i)));
      for (int i = 0; i < frt_pkg::FRAGMENTS; i++)
         send_packet(make_packet(1'b1, 16'hABCD, 5'(i), i == frt_pkg::FRAGMENTS - 1,
                                 11'd2047));

      foreach (seq_pool[i]) seq_pool[i] = 16'($urandom);
      sent = 0;
      while (sent < 1700) begin
         int burst;
         burst = $urandom_range(1, 12);
         for (int b = 0; b < burst; b++) begin
            case ($urandom_range(0, 9))
               0: p = make_packet(1'b0, 16'($urandom), 5'($urandom), 1'($urandom),
                                  ($urandom_range(0, 3) == 0) ? 11'd0 : 11'($urandom));
               1: p = make_packet(1'b1, seq_pool[$urandom_range(0, 11)], 5'($urandom),
                                  1'($urandom), 11'($urandom));
               default: begin
                  send_message(($urandom_range(0, 3) == 0) ? 16'($urandom)
                                                           : seq_pool[$urandom_range(0, 11)],
                               msg_items);
                  sent += msg_items;
                  continue;
               end
            endcase
            send_packet(p);
            sent++;
         end
         if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 10));
         if (sent > 400 && !hold_done && !long_hold) long_hold = 1;
         if (sent > 900 && !drained) begin
            drained = 1;
            idle_sender(1);
            while (pending_count != 0) @(negedge clock);
         end
      end
      idle_sender(1);
      while (pending_count != 0) @(negedge clock);
      repeat (40) @(negedge clock);
      if (fail_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("Mismatches found");
      $finish;
   end
endmodule
